// ===== rtl/base32_stream_encoder_unit_defines.svh =====
// assertion macros used by the top-level rtl
`ifndef BASE32_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE32_STREAM_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define B32E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b32e check failed");

// next-cycle implication
`define B32E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b32e check failed");

`endif

// ===== rtl/b32e_pkg.sv =====
package b32e_pkg;

    localparam logic [6:0] PAD_CHAR     = 7'h3d;
    localparam logic [6:0] NEWLINE_CHAR = 7'h0a;
    localparam logic [7:0] GPL_RESET    = 8'd8;
    localparam logic       CMD_DATA     = 1'b0;
    localparam logic       CMD_END      = 1'b1;
    localparam int         QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [39:0] bits;
        logic [2:0]  n_bytes;
        logic        newline;
    } t_job;

    function automatic logic [6:0] sym_char(input logic [4:0] v);
        logic [6:0] c;
        if (v < 5'd26) begin
            c = 7'h41 + {2'b00, v};
        end else begin
            c = 7'h32 + {2'b00, v} - 7'd26;
        end
        return c;
    endfunction

    function automatic logic [3:0] used_syms(input logic [2:0] n);
        logic [3:0] u;
        case (n)
            3'd1: u = 4'd2;
            3'd2: u = 4'd4;
            3'd3: u = 4'd5;
            3'd4: u = 4'd7;
            default: u = 4'd8;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/b32e_front.sv =====
module b32e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  b32e_pkg::t_in   i_in_data,
    input  logic            i_q_full,
    output logic            o_push,
    output b32e_pkg::t_job  o_job
);

    logic [7:0] r_gpl;
    logic [7:0] r_pend [4];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [7:0] r_gol;
    logic [7:0] n_gol;
    logic       w_acc;
    logic [8:0] w_next;
    logic [7:0] w_mask [4];

    assign o_in_ready = !i_q_full;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_next     = {1'b0, r_gol} + 9'd1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mask[k] = (3'(k) < r_cnt) ? r_pend[k] : 8'h00;
        end
    end

    always_comb begin
        n_cnt        = r_cnt;
        n_gol        = r_gol;
        o_push       = 1'b0;
        o_job.bits   = {w_mask[0], w_mask[1], w_mask[2], w_mask[3], 8'h00};
        o_job.n_bytes = r_cnt;
        o_job.newline = 1'b0;
        if (w_acc) begin
            if (i_in_data.command == b32e_pkg::CMD_END) begin
                o_push = (r_cnt != 3'd0);
                n_cnt  = 3'd0;
                n_gol  = 8'd0;
            end else if (r_cnt < 3'd4) begin
                n_cnt = r_cnt + 3'd1;
            end else begin
                o_push        = 1'b1;
                o_job.bits    = {r_pend[0], r_pend[1], r_pend[2], r_pend[3],
                                 i_in_data.data_byte};
                o_job.n_bytes = 3'd5;
                n_cnt         = 3'd0;
                if (r_gpl != 8'd0) begin
                    if (w_next >= {1'b0, r_gpl}) begin
                        o_job.newline = 1'b1;
                        n_gol         = 8'd0;
                    end else begin
                        n_gol = w_next[7:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl <= b32e_pkg::GPL_RESET;
            r_cnt <= 3'd0;
            r_gol <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_gpl <= i_cfg_wdata;
            end
            r_cnt <= n_cnt;
            r_gol <= n_gol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.command == b32e_pkg::CMD_DATA && r_cnt < 3'd4) begin
            r_pend[r_cnt[1:0]] <= i_in_data.data_byte;
        end
    end

endmodule

// ===== rtl/b32e_queue.sv =====
module b32e_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b32e_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output b32e_pkg::t_job  o_job
);

    b32e_pkg::t_job r_mem [b32e_pkg::QUEUE_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_cnt == 2'(b32e_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/b32e_back.sv =====
module b32e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  b32e_pkg::t_job  i_q_job,
    output logic            o_pop,
    output logic            o_busy,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output b32e_pkg::t_out  o_out_data
);

    b32e_pkg::t_job r_job;
    logic           r_busy;
    logic [3:0]     r_idx;
    logic           r_out_valid;
    b32e_pkg::t_out r_out;
    logic           w_adv;
    logic           w_emit;
    logic           w_last;
    logic [4:0]     w_sym [8];
    logic [6:0]     w_char;

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_emit = w_adv && r_busy;
    assign w_last = (r_idx == (r_job.newline ? 4'd8 : 4'd7));
    assign o_pop  = w_adv && (!r_busy || w_last) && i_q_valid;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_sym[k] = r_job.bits[39 - 5 * k -: 5];
        end
    end

    always_comb begin
        if (r_idx[3]) begin
            w_char = b32e_pkg::NEWLINE_CHAR;
        end else if (r_idx < b32e_pkg::used_syms(r_job.n_bytes)) begin
            w_char = b32e_pkg::sym_char(w_sym[r_idx[2:0]]);
        end else begin
            w_char = b32e_pkg::PAD_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_adv) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (w_emit) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (w_emit) begin
            r_out.out_char    <= w_char;
            r_out.last_of_run <= w_last;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/base32_stream_encoder_unit.sv =====
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_in_data  (command, data_byte)
// output  | out       | o_out_valid / i_out_ready | o_out_data (out_char, last_of_run)
// config  | in        | i_cfg_we                  | i_cfg_wdata (groups_per_line)
//
// the front accepts an input transfer while the two-entry job queue has room
// the back emits one character per cycle while the output is not stalled: 8 per group, 9 with a newline
// sustained rate is set by the back
// output register holds o_out_data during a stall; the job queue decouples the stall from the input side
// synchronous active-low reset clears counts, queue and output valid, and sets groups_per_line to 8
`include "base32_stream_encoder_unit_defines.svh"

module base32_stream_encoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  b32e_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output b32e_pkg::t_out  o_out_data
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_full;
    logic           w_q_valid;
    logic           w_busy;
    logic           w_nl_out;
    b32e_pkg::t_job w_front_job;
    b32e_pkg::t_job w_q_job;

    b32e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    b32e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    b32e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_pop       (w_pop),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign w_nl_out = o_out_valid && (o_out_data.out_char == b32e_pkg::NEWLINE_CHAR);

    `B32E_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_full)
    `B32E_ASSERT_NOW(a_newline_last, i_clk, i_rst_n, w_nl_out, o_out_data.last_of_run)
    `B32E_ASSERT_NOW(a_mid_run_busy, i_clk, i_rst_n, o_out_valid && !o_out_data.last_of_run, w_busy)
    `B32E_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, w_pop, w_busy)

endmodule
